FILE: src/ptcap_pkg.sv
package ptcap_pkg;

  // Capture geometry.
  localparam int unsigned PRE_DEPTH  = 32;
  localparam int unsigned POST_DEPTH = 32;

  localparam int unsigned PTR_W  = (PRE_DEPTH > 1) ? $clog2(PRE_DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(PRE_DEPTH + 1);
  localparam int unsigned POST_W = $clog2(POST_DEPTH + 1);

  localparam logic signed [15:0] TRIG_LEVEL_RST = 16'sd4096;

  // One stored or emitted sample.
  typedef struct packed {
    logic [31:0]        stamp;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
  } ptcap_sample_t;

  // Source of the next output beat.
  typedef enum logic [1:0] {
    SEL_MEM,
    SEL_HOLD,
    SEL_IN
  } ptcap_sel_e;

  // Controller to datapath.
  typedef struct packed {
    logic       hist_wr;
    logic       trig;
    logic       drain_rd;
    logic       out_load;
    ptcap_sel_e out_sel;
  } ptcap_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic trig_hit;
    logic hist_empty;
    logic drain_done;
    logic hold_last;
    logic pass_last;
  } ptcap_sts_t;

endpackage

FILE: src/ptcap_sample_if.sv
interface ptcap_sample_if;
  logic               valid;
  logic               ready;
  logic [31:0]        sample_time;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;

  modport source (output valid, sample_time, accel_x, accel_y, accel_z, input ready);
  modport sink   (input valid, sample_time, accel_x, accel_y, accel_z, output ready);
endinterface

FILE: src/ptcap_result_if.sv
interface ptcap_result_if;
  logic               valid;
  logic               ready;
  logic [31:0]        out_time;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  logic signed [15:0] out_z;
  logic               after_trigger;
  logic               last;

  modport source (output valid, out_time, out_x, out_y, out_z, after_trigger, last,
                  input ready);
  modport sink   (input valid, out_time, out_x, out_y, out_z, after_trigger, last,
                  output ready);
endinterface

FILE: src/ptcap_cfg_if.sv
interface ptcap_cfg_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] trigger_level;

  modport source (output valid, trigger_level, input ready);
  modport sink   (input valid, trigger_level, output ready);
endinterface

FILE: src/ptcap_datapath.sv
module ptcap_datapath import ptcap_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic signed [15:0] cfg_level_i,
  input  ptcap_sample_t      in_sample_i,
  input  ptcap_cmd_t         cmd_i,
  output ptcap_sts_t         sts_o,
  output ptcap_sample_t      out_sample_o,
  output logic               out_after_o,
  output logic               out_last_o
);

  localparam logic [PTR_W-1:0]  PTR_MAX  = PTR_W'(PRE_DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(PRE_DEPTH);

  ptcap_sample_t      mem_q [PRE_DEPTH];
  ptcap_sample_t      rd_q;
  ptcap_sample_t      hold_q;
  ptcap_sample_t      out_q;
  logic               after_q;
  logic               last_q;
  logic signed [15:0] level_q;
  logic [PTR_W-1:0]   wr_slot_q;
  logic [PTR_W-1:0]   rd_ptr_q;
  logic [FILL_W-1:0]  fill_q;
  logic [FILL_W-1:0]  left_q;
  logic [POST_W-1:0]  post_cnt_q;
  logic [POST_W:0]    post_next;
  logic               pass_last;

  // Trigger level register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= TRIG_LEVEL_RST;
    end else if (cfg_we_i) begin
      level_q <= cfg_level_i;
    end
  end

  // History ring: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.hist_wr) begin
      mem_q[wr_slot_q] <= in_sample_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.drain_rd) begin
      rd_q <= mem_q[rd_ptr_q];
    end
  end

  // Ring pointers and counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_slot_q  <= '0;
      fill_q     <= '0;
      rd_ptr_q   <= '0;
      left_q     <= '0;
      post_cnt_q <= '0;
    end else begin
      if (cmd_i.hist_wr) begin
        wr_slot_q <= (wr_slot_q == PTR_MAX) ? '0 : wr_slot_q + 1'b1;
        if (fill_q != FILL_MAX) begin
          fill_q <= fill_q + 1'b1;
        end
      end
      if (cmd_i.trig) begin
        // A full ring starts at the oldest entry, which is the next write slot.
        rd_ptr_q <= (fill_q != FILL_MAX) ? '0 : wr_slot_q;
        left_q   <= fill_q;
      end else if (cmd_i.drain_rd) begin
        rd_ptr_q <= (rd_ptr_q == PTR_MAX) ? '0 : rd_ptr_q + 1'b1;
        left_q   <= left_q - 1'b1;
      end
      if (cmd_i.out_load && cmd_i.out_sel == SEL_HOLD) begin
        post_cnt_q <= POST_W'(1);
      end else if (cmd_i.out_load && cmd_i.out_sel == SEL_IN) begin
        post_cnt_q <= post_next[POST_W-1:0];
      end
    end
  end

  // The trigger sample is held while the history drains.
  always_ff @(posedge clk_i) begin
    if (cmd_i.trig) begin
      hold_q <= in_sample_i;
    end
  end

  assign post_next = {1'b0, post_cnt_q} + 1'b1;
  assign pass_last = (post_next >= (POST_W + 1)'(POST_DEPTH));

  // Output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      case (cmd_i.out_sel)
        SEL_MEM: begin
          out_q   <= rd_q;
          after_q <= 1'b0;
          last_q  <= 1'b0;
        end
        SEL_HOLD: begin
          out_q   <= hold_q;
          after_q <= 1'b1;
          last_q  <= (POST_DEPTH <= 1);
        end
        default: begin
          out_q   <= in_sample_i;
          after_q <= 1'b1;
          last_q  <= pass_last;
        end
      endcase
    end
  end

  assign out_sample_o = out_q;
  assign out_after_o  = after_q;
  assign out_last_o   = last_q;

  // Status toward the controller.
  always_comb begin
    sts_o.trig_hit   = (in_sample_i.ay >= level_q);
    sts_o.hist_empty = (fill_q == '0);
    sts_o.drain_done = (left_q == '0);
    sts_o.hold_last  = (POST_DEPTH <= 1);
    sts_o.pass_last  = pass_last;
  end

endmodule

FILE: src/ptcap_ctrl.sv
module ptcap_ctrl import ptcap_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  ptcap_sts_t sts_i,
  output ptcap_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_WAIT,
    ST_READ,
    ST_LOAD,
    ST_TRIG,
    ST_POST,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   in_acc;

  assign out_free = !out_valid_q || out_ready_i;
  assign in_acc   = in_valid_i && in_ready_o;

  // Next state and datapath commands.
  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    cmd_o.out_sel = SEL_IN;
    unique case (state_q)
      ST_WAIT: begin
        in_ready_o = 1'b1;
        if (in_acc) begin
          if (sts_i.trig_hit) begin
            cmd_o.trig = 1'b1;
            state_d    = sts_i.hist_empty ? ST_TRIG : ST_READ;
          end else begin
            cmd_o.hist_wr = 1'b1;
          end
        end
      end
      ST_READ: begin
        cmd_o.drain_rd = 1'b1;
        state_d        = ST_LOAD;
      end
      ST_LOAD: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = SEL_MEM;
          state_d        = sts_i.drain_done ? ST_TRIG : ST_READ;
        end
      end
      ST_TRIG: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = SEL_HOLD;
          state_d        = sts_i.hold_last ? ST_DONE : ST_POST;
        end
      end
      ST_POST: begin
        in_ready_o = out_free;
        if (in_acc) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = SEL_IN;
          if (sts_i.pass_last) begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        // Capture finished: samples are taken and dropped.
        in_ready_o = 1'b1;
      end
      default: begin
        state_d = ST_DONE;
      end
    endcase
  end

  assign out_valid_d = cmd_o.out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  // State and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_WAIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: src/pretrigger_sample_capture_top.sv
// Pre-trigger capture of timestamped three-axis samples. Until the trigger fires,
// every sample beat is accepted with ready held high and written into a ring
// holding the latest PRE_DEPTH samples. The first sample whose Y value is at or
// above trigger_level fires the trigger; the input then stalls while the ring
// drains oldest first, each stored sample taking one memory read and one load of
// the output register, followed by a load of the trigger sample, and each load
// also waits while the output side holds ready low. Post-trigger samples pass
// through the output register at one beat per cycle while the output side keeps
// ready high, until POST_DEPTH beats with after_trigger set have gone out; the
// final one carries last, and later samples are taken and dropped until reset.
// trigger_level may be written at any time the block is idle and is always ready.
module pretrigger_sample_capture_top import ptcap_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ptcap_cfg_if.sink      cfg_i,
  ptcap_sample_if.sink   sample_i,
  ptcap_result_if.source result_o
);

  ptcap_cmd_t    cmd;
  ptcap_sts_t    sts;
  ptcap_sample_t in_sample;
  ptcap_sample_t out_sample;
  logic          out_after;
  logic          out_last;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    in_sample.stamp = sample_i.sample_time;
    in_sample.ax    = sample_i.accel_x;
    in_sample.ay    = sample_i.accel_y;
    in_sample.az    = sample_i.accel_z;
  end

  ptcap_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_i.valid),
    .in_ready_o  (sample_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ptcap_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_i.valid),
    .cfg_level_i  (cfg_i.trigger_level),
    .in_sample_i  (in_sample),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_sample_o (out_sample),
    .out_after_o  (out_after),
    .out_last_o   (out_last)
  );

  assign result_o.out_time      = out_sample.stamp;
  assign result_o.out_x         = out_sample.ax;
  assign result_o.out_y         = out_sample.ay;
  assign result_o.out_z         = out_sample.az;
  assign result_o.after_trigger = out_after;
  assign result_o.last          = out_last;

  // The output register is never overwritten while it holds an untaken beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!result_o.valid || result_o.ready))
    else $error("output beat overwritten before it was taken");

  // Nothing is emitted while history is still being recorded.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.hist_wr |-> !result_o.valid)
    else $error("output beat pending while recording history");

  // After the last beat is taken, the capture emits nothing more.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.ready && result_o.last) |=> !result_o.valid)
    else $error("output beat after the last beat of the capture");

  // History is never written and drained in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.hist_wr && (cmd.drain_rd || cmd.trig)))
    else $error("history write collides with trigger or drain");

endmodule

FILE: tb/sv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ptcap_pkg::*;

  // Cycles without any accepted beat before the run is declared hung.
  localparam int unsigned STALL_LIMIT = 3000;
  // Length of the one long receiver hold-off, started when the trigger fires.
  localparam int unsigned LONG_HOLD   = 160;
  // Settling time after the last beat, longer than one ring write.
  localparam int unsigned SETTLE      = 8;

  typedef enum logic [1:0] {
    CAP_WAIT,
    CAP_POST,
    CAP_DONE
  } capture_state_e;

  // One expected output beat.
  typedef struct packed {
    logic [31:0]        stamp;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic               trig_flag;
    logic               last_flag;
  } capture_beat_t;

  logic clk;
  logic rst_n;

  ptcap_cfg_if    cfg_bus ();
  ptcap_sample_if smp_bus ();
  ptcap_result_if res_bus ();

  pretrigger_sample_capture_top i_dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .cfg_i    (cfg_bus),
    .sample_i (smp_bus),
    .result_o (res_bus)
  );

  // Samples waiting for the driver, and beats the capture logic owes us.
  ptcap_sample_t sample_q[$];
  capture_beat_t capture_q[$];

  int unsigned items_queued;
  int unsigned items_taken;
  int unsigned error_count;
  int unsigned idle_cycles;
  logic        capture_fired;

  // Shadow of the capture state.
  ptcap_sample_t      ring_mem [PRE_DEPTH];
  int unsigned        ring_wr;
  int unsigned        ring_fill;
  int unsigned        post_count;
  capture_state_e     cap_state;
  logic signed [15:0] level_shadow;
  logic [31:0]        stamp_now;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic capture_beat_t make_beat(input ptcap_sample_t s, input logic trig_flag,
                                              input logic last_flag);
    capture_beat_t b;
    b.stamp     = s.stamp;
    b.ax        = s.ax;
    b.ay        = s.ay;
    b.az        = s.az;
    b.trig_flag = trig_flag;
    b.last_flag = last_flag;
    return b;
  endfunction

  // Works out the beats that one accepted sample causes.
  task automatic predict_capture(input ptcap_sample_t s);
    int unsigned first;
    logic        is_last;
    case (cap_state)
      CAP_WAIT: begin
        if ($signed(s.ay) >= $signed(level_shadow)) begin
          // History goes out oldest first, then the trigger sample itself.
          first = (ring_fill < PRE_DEPTH) ? 0 : ring_wr;
          for (int i = 0; i < ring_fill; i++) begin
            capture_q.push_back(make_beat(ring_mem[(first + i) % PRE_DEPTH], 1'b0, 1'b0));
          end
          post_count = 1;
          is_last = (post_count >= POST_DEPTH);
          capture_q.push_back(make_beat(s, 1'b1, is_last));
          cap_state = is_last ? CAP_DONE : CAP_POST;
          capture_fired <= 1'b1;
        end else begin
          ring_mem[ring_wr] = s;
          ring_wr = (ring_wr + 1) % PRE_DEPTH;
          if (ring_fill < PRE_DEPTH) begin
            ring_fill++;
          end
        end
      end
      CAP_POST: begin
        post_count++;
        is_last = (post_count >= POST_DEPTH);
        capture_q.push_back(make_beat(s, 1'b1, is_last));
        if (is_last) begin
          cap_state = CAP_DONE;
        end
      end
      default: begin
        // Capture finished: the sample is dropped.
      end
    endcase
  endtask

  function automatic ptcap_sample_t mk_sample(input logic [31:0] t, input int x, input int y,
                                              input int z);
    ptcap_sample_t s;
    s.stamp = t;
    s.ax    = x[15:0];
    s.ay    = y[15:0];
    s.az    = z[15:0];
    return s;
  endfunction

  // Random sample with Y in [y_lo, y_hi]; timestamps mostly advance.
  function automatic ptcap_sample_t rand_sample(input int y_lo, input int y_hi);
    if ($urandom_range(0, 15) == 0) begin
      stamp_now = $urandom();
    end else begin
      stamp_now = stamp_now + $urandom_range(1, 5000);
    end
    return mk_sample(stamp_now, $urandom(), y_lo + int'($urandom_range(0, y_hi - y_lo)),
                     $urandom());
  endfunction

  task automatic push_sample(input ptcap_sample_t s);
    sample_q.push_back(s);
    items_queued++;
  endtask

  // Returns at a falling edge once every sample is taken and every beat has come.
  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (items_taken != items_queued || capture_q.size() != 0);
  endtask

  task automatic write_level(input logic signed [15:0] lvl);
    @(posedge clk);
    cfg_bus.valid         <= 1'b1;
    cfg_bus.trigger_level <= lvl;
    do begin
      @(posedge clk);
    end while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    level_shadow = lvl;
  endtask

  // Sample driver: bursts of random length separated by random gaps.
  int unsigned   burst_left;
  int unsigned   gap_left;
  ptcap_sample_t next_sample;

  always @(posedge clk) begin
    if (!rst_n) begin
      smp_bus.valid <= 1'b0;
      burst_left    <= 1;
      gap_left      <= 0;
    end else if (!smp_bus.valid || smp_bus.ready) begin
      if (gap_left != 0) begin
        gap_left      <= gap_left - 1;
        smp_bus.valid <= 1'b0;
      end else if (sample_q.size() != 0) begin
        next_sample = sample_q.pop_front();
        smp_bus.valid       <= 1'b1;
        smp_bus.sample_time <= next_sample.stamp;
        smp_bus.accel_x     <= next_sample.ax;
        smp_bus.accel_y     <= next_sample.ay;
        smp_bus.accel_z     <= next_sample.az;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        smp_bus.valid <= 1'b0;
      end
    end
  end

  // Sample monitor: every accepted beat updates the shadow state.
  always @(posedge clk) begin : sample_monitor
    ptcap_sample_t s;
    if (rst_n && smp_bus.valid && smp_bus.ready) begin
      s.stamp = smp_bus.sample_time;
      s.ax    = smp_bus.accel_x;
      s.ay    = smp_bus.accel_y;
      s.az    = smp_bus.accel_z;
      predict_capture(s);
      items_taken <= items_taken + 1;
    end
  end

  // Receiver: one long hold-off at the trigger, otherwise a changing stall mode.
  int unsigned hold_left;
  logic        hold_used;
  int unsigned stall_mode;
  int unsigned mode_left;
  logic        toggle;

  always @(posedge clk) begin
    if (!rst_n) begin
      res_bus.ready <= 1'b0;
      hold_left     <= 0;
      hold_used     <= 1'b0;
      stall_mode    <= 0;
      mode_left     <= 0;
      toggle        <= 1'b0;
    end else begin
      toggle <= ~toggle;
      if (hold_left != 0) begin
        hold_left     <= hold_left - 1;
        res_bus.ready <= 1'b0;
      end else if (capture_fired && !hold_used) begin
        hold_used     <= 1'b1;
        hold_left     <= LONG_HOLD;
        res_bus.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode <= $urandom_range(0, 3);
          mode_left  <= $urandom_range(8, 48);
        end else begin
          mode_left <= mode_left - 1;
        end
        case (stall_mode)
          0:       res_bus.ready <= 1'b1;
          1:       res_bus.ready <= ($urandom_range(0, 99) < 75);
          2:       res_bus.ready <= ($urandom_range(0, 99) < 35);
          default: res_bus.ready <= toggle;
        endcase
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
      error_count++;
    end
  endtask

  // Result monitor: each accepted beat is compared with the oldest expectation.
  always @(posedge clk) begin : result_monitor
    capture_beat_t exp_beat;
    if (rst_n && res_bus.valid && res_bus.ready) begin
      if (capture_q.size() == 0) begin
        $error("result beat with no expectation: time 0x%0h", res_bus.out_time);
        error_count++;
      end else begin
        exp_beat = capture_q.pop_front();
        check_field("out_time", exp_beat.stamp, res_bus.out_time);
        check_field("out_x", exp_beat.ax, res_bus.out_x);
        check_field("out_y", exp_beat.ay, res_bus.out_y);
        check_field("out_z", exp_beat.az, res_bus.out_z);
        check_field("after_trigger", exp_beat.trig_flag, res_bus.after_trigger);
        check_field("last", exp_beat.last_flag, res_bus.last);
      end
    end
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((smp_bus.valid && smp_bus.ready) || (res_bus.valid && res_bus.ready) ||
                 (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $error("no beat accepted for %0d cycles", STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus and end of run.
  initial begin : stimulus
    int lvl;
    int lvl_pick;
    int y;
    rst_n                 = 1'b0;
    cfg_bus.valid         = 1'b0;
    cfg_bus.trigger_level = '0;
    smp_bus.valid         = 1'b0;
    smp_bus.sample_time   = '0;
    smp_bus.accel_x       = '0;
    smp_bus.accel_y       = '0;
    smp_bus.accel_z       = '0;
    res_bus.ready         = 1'b0;
    items_queued          = 0;
    items_taken           = 0;
    error_count           = 0;
    capture_fired         = 1'b0;
    ring_wr               = 0;
    ring_fill             = 0;
    post_count            = 0;
    cap_state             = CAP_WAIT;
    level_shadow          = TRIG_LEVEL_RST;
    stamp_now             = $urandom();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed samples against the reset trigger level, all Y below it, one just below.
    push_sample(mk_sample(32'h0000_0000, -32768, -32768, -32768));
    push_sample(mk_sample(32'hFFFF_FFFF, 32767, 4095, 32767));
    push_sample(mk_sample(32'h0000_0001, 0, 0, 0));
    push_sample(mk_sample(32'h8000_0000, -1, -1, -1));
    push_sample(mk_sample(32'h5555_5555, 21845, 1, -21846));
    push_sample(mk_sample(32'hAAAA_AAAA, -21846, 4000, 21845));
    wait_drained();
    repeat (SETTLE) @(negedge clk);

    // Highest level: every Y but the maximum stays below it.
    write_level(16'sd32767);
    push_sample(mk_sample(32'h7FFF_FFFF, 1, 32766, -1));
    push_sample(mk_sample(32'h0000_FFFF, 32767, 21845, -32768));
    push_sample(mk_sample(32'hFFFF_0000, -32768, -21846, 32767));
    push_sample(mk_sample(32'h1234_5678, 21845, 16384, 0));
    push_sample(mk_sample(32'h8765_4321, -21846, -32768, 1));
    push_sample(mk_sample(32'hFFFF_FFFE, 0, 30000, 21845));
    push_sample(mk_sample(32'h0000_0002, -1, -1, -21846));
    push_sample(mk_sample(32'hC000_0000, 16384, 8192, -16384));
    wait_drained();
    repeat (SETTLE) @(negedge clk);

    // Random levels with long runs below them, so the ring wraps many times.
    repeat (2) begin
      lvl = int'($urandom_range(0, 40000)) - 20000;
      write_level(lvl[15:0]);
      repeat (180) begin
        if ($urandom_range(0, 9) == 0) begin
          push_sample(rand_sample(lvl - 1, lvl - 1));
        end else begin
          push_sample(rand_sample(-32768, lvl - 1));
        end
      end
      wait_drained();
      repeat (SETTLE) @(negedge clk);
    end

    // Near the bottom only the minimum Y stays below the level.
    write_level(-16'sd32767);
    repeat (6) push_sample(rand_sample(-32768, -32768));
    wait_drained();
    repeat (SETTLE) @(negedge clk);

    // Trigger phase: level at either extreme or random, Y hitting it exactly above the minimum level.
    lvl_pick = $urandom_range(0, 2);
    case (lvl_pick)
      0:       lvl = 32767;
      1:       lvl = -32768;
      default: lvl = int'($urandom_range(0, 40000)) - 20000;
    endcase
    write_level(lvl[15:0]);
    if (lvl > -32768) begin
      repeat (3) push_sample(rand_sample(lvl - 1, lvl - 1));
      y = lvl;
    end else begin
      y = int'($urandom_range(0, 65535)) - 32768;
    end
    push_sample(rand_sample(y, y));
    repeat (12) push_sample(rand_sample(-32768, 32767));
    // Let the drain and the first post-trigger beats finish before going on.
    wait_drained();
    repeat (POST_DEPTH - 13) push_sample(rand_sample(-32768, 32767));
    wait_drained();

    // After the last beat the block must drop everything, even high Y values.
    repeat (20) begin
      if ($urandom_range(0, 3) == 0) begin
        push_sample(rand_sample(32767, 32767));
      end else begin
        push_sample(rand_sample(-32768, 32767));
      end
    end
    wait_drained();
    repeat (20) @(negedge clk);

    if (capture_q.size() != 0) begin
      $error("%0d expected result beats never arrived", capture_q.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/ptcap_pkg.sv
src/ptcap_sample_if.sv
src/ptcap_result_if.sv
src/ptcap_cfg_if.sv
src/ptcap_datapath.sv
src/ptcap_ctrl.sv
src/pretrigger_sample_capture_top.sv
tb/sv/tb.sv
